[sv/xmbs_pkg.sv]
`default_nettype none

package xmbs_pkg;

    // block geometry defaults
    localparam int LONG_BLOCK_DEF  = 1024;
    localparam int LENGTH_BITS_DEF = 24;
    localparam int SHORT_BLOCK     = 128;

    // line characters
    localparam logic [7:0] PAD_BYTE   = 8'h1A;
    localparam logic [7:0] TYPE_SHORT = 8'h01;
    localparam logic [7:0] TYPE_LONG  = 8'h02;
    localparam logic [7:0] CH_ACK     = 8'h06;
    localparam logic [7:0] CH_NAK     = 8'h15;
    localparam logic [7:0] CH_CRC     = 8'h43;
    localparam logic [7:0] CH_EOT     = 8'h04;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // item commands
    localparam logic [1:0] CMD_IMAGE = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_SLOT  = 2'd2;

    // protocol phases
    localparam logic [2:0] PH_LOAD       = 3'd0;
    localparam logic [2:0] PH_WAIT_START = 3'd1;
    localparam logic [2:0] PH_SEND       = 3'd2;
    localparam logic [2:0] PH_WAIT_REPLY = 3'd3;
    localparam logic [2:0] PH_SEND_END   = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;

    // line byte source, resolved one stage after the store read
    localparam logic [2:0] SEL_NONE   = 3'd0;
    localparam logic [2:0] SEL_IMM    = 3'd1;
    localparam logic [2:0] SEL_DATA   = 3'd2;
    localparam logic [2:0] SEL_PAD    = 3'd3;
    localparam logic [2:0] SEL_CHK_HI = 3'd4;
    localparam logic [2:0] SEL_CHK_LO = 3'd5;

    typedef struct packed {
        logic [2:0] sel;   // byte source
        logic [7:0] imm;   // header or EOT byte
        logic       crc;   // check mode of the block
        logic       clr;   // clear check after this item
    } t_byte_ctl;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/xmbs_ram.sv]
`default_nettype none

module xmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/xmbs_check.sv]
`default_nettype none

// Line byte select and check accumulator (sum or CRC-16).
module xmbs_check (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire xmbs_pkg::t_byte_ctl i_ctl,
    input  wire logic [7:0]          i_rd_data,
    output      logic [7:0]          o_byte
);

    logic [15:0] r_check;
    logic [15:0] n_check;
    logic [7:0]  w_byte;

    always_comb begin
        case (i_ctl.sel)
            xmbs_pkg::SEL_IMM:    w_byte = i_ctl.imm;
            xmbs_pkg::SEL_DATA:   w_byte = i_rd_data;
            xmbs_pkg::SEL_PAD:    w_byte = xmbs_pkg::PAD_BYTE;
            xmbs_pkg::SEL_CHK_HI: w_byte = r_check[15:8];
            xmbs_pkg::SEL_CHK_LO: w_byte = r_check[7:0];
            default:              w_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_check = r_check;
        if (i_adv) begin
            if (i_ctl.sel == xmbs_pkg::SEL_DATA || i_ctl.sel == xmbs_pkg::SEL_PAD) begin
                n_check = i_ctl.crc ? xmbs_pkg::crc_update(r_check, w_byte)
                                    : {8'h00, r_check[7:0] + w_byte};
            end
            if (i_ctl.clr) begin
                n_check = 16'h0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= 16'h0000;
        end else begin
            r_check <= n_check;
        end
    end

    assign o_byte = w_byte;

endmodule

`default_nettype wire

[sv/xmodem_block_sender.sv]
// XMODEM block sender. Every input item is one of: an image byte offered
// (tuser = 0), a byte received from the partner (tuser = 1), or a free
// transmit slot (tuser = 2); each accepted item yields exactly one result
// item. Image bytes fill a block store (one 8-bit RAM of LONG_BLOCK bytes);
// blocks go out as 128-byte (0x01) or LONG_BLOCK-byte (0x02) blocks padded
// with 0x1A, checked by an 8-bit sum after NAK or CRC-16 after 'C'. ACK moves
// to the next block or to EOT, anything else resends. Set image_length
// (addr 0) and force_short (addr 4) before the first byte goes in.
// Throughput is one item per clock while the result side takes items; an
// item's result passes through the store's registered read (mid stage),
// then the result register, where the line byte and its check update are
// settled. No clearing pass after reset.
`default_nettype none

module xmodem_block_sender #(
    parameter int LONG_BLOCK  = xmbs_pkg::LONG_BLOCK_DEF,
    parameter int LENGTH_BITS = xmbs_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item in
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data[7:0]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    // item out
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // tx_valid[0], tx_byte[8:1], image_taken[9],
                                             // echo_valid[10], echo_byte[18:11],
                                             // phase[21:19], current_block[29:22]
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int CW = $clog2(LONG_BLOCK + 1);      // fill/take counts
    localparam int IW = $clog2(LONG_BLOCK + 6);      // line index
    localparam int AW = $clog2(LONG_BLOCK);          // store address
    localparam int MW = (LENGTH_BITS > CW) ? LENGTH_BITS : CW;

    // ---------------------------------------------------------------------
    // Block state
    // ---------------------------------------------------------------------
    logic [LENGTH_BITS-1:0] r_len,   n_len;
    logic                   r_force, n_force;
    logic [CW-1:0]          r_fill,  n_fill;
    logic [CW-1:0]          r_take,  n_take;
    logic                   r_long,  n_long;
    logic [LENGTH_BITS-1:0] r_rem,   n_rem;
    logic [7:0]             r_block, n_block;
    logic [IW-1:0]          r_idx,   n_idx;
    logic [2:0]             r_phase, n_phase;
    logic                   r_start, n_start;
    logic                   r_crc,   n_crc;
    logic                   r_lv,    n_lv;      // reply latch valid
    logic [7:0]             r_lb,    n_lb;      // reply latch byte

    // mid stage: store read in flight
    logic                   r_mv;
    xmbs_pkg::t_byte_ctl    r_m_ctl, w_ctl;
    logic                   r_m_taken, w_taken;
    logic                   r_m_ev,    w_ev;
    logic [7:0]             r_m_eb,    w_eb;

    // result register
    logic                   r_ov;
    logic [31:0]            r_tdata;

    logic                   w_cfg_we;
    logic                   w_acc;
    logic                   w_adv;
    logic [CW:0]            w_size;
    logic [IW-1:0]          w_len;
    logic [IW-1:0]          w_total;
    logic [IW-1:0]          w_d;
    logic                   w_we;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic [7:0]             w_rdata;
    logic [7:0]             w_byte;

    // returns {long, take} for a block of the given remaining length
    function automatic logic [CW:0] f_size(input logic [LENGTH_BITS-1:0] rem,
                                           input logic frc);
        logic          lng;
        logic [MW-1:0] re;
        logic [MW-1:0] sz;
        re  = MW'(rem);
        lng = !frc && (re > MW'(xmbs_pkg::SHORT_BLOCK));
        sz  = lng ? MW'(LONG_BLOCK) : MW'(xmbs_pkg::SHORT_BLOCK);
        return {lng, (re < sz) ? re[CW-1:0] : sz[CW-1:0]};
    endfunction

    assign w_cfg_we      = psel && penable && pwrite;
    assign w_adv         = r_mv && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_mv || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_len   = r_long ? IW'(LONG_BLOCK) : IW'(xmbs_pkg::SHORT_BLOCK);
    assign w_total = w_len + (r_crc ? IW'(5) : IW'(4));
    assign w_d     = r_idx - IW'(3);

    // ---------------------------------------------------------------------
    // Item decode and state update
    // ---------------------------------------------------------------------
    always_comb begin
        n_len   = r_len;
        n_force = r_force;
        n_fill  = r_fill;
        n_take  = r_take;
        n_long  = r_long;
        n_rem   = r_rem;
        n_block = r_block;
        n_idx   = r_idx;
        n_phase = r_phase;
        n_start = r_start;
        n_crc   = r_crc;
        n_lv    = r_lv;
        n_lb    = r_lb;
        w_ctl   = '{sel: xmbs_pkg::SEL_NONE, imm: 8'h00, crc: r_crc, clr: 1'b0};
        w_taken = 1'b0;
        w_ev    = 1'b0;
        w_eb    = 8'h00;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_raddr = w_d[AW-1:0];
        w_size  = '0;

        if (w_cfg_we) begin
            if (paddr[2]) begin
                n_force = pwdata[0];
            end else begin
                n_len = pwdata[LENGTH_BITS-1:0];
            end
            // first block still empty: resize from the new settings
            if (r_phase == xmbs_pkg::PH_LOAD && r_block == 8'd1 &&
                r_fill == '0 && !r_start) begin
                n_rem  = n_len;
                w_size = f_size(n_len, n_force);
                n_long = w_size[CW];
                n_take = w_size[CW-1:0];
            end
        end else if (w_acc) begin
            case (s_axis_tuser)
                xmbs_pkg::CMD_IMAGE: begin
                    if (r_phase == xmbs_pkg::PH_LOAD && r_fill < r_take) begin
                        w_we    = 1'b1;
                        n_fill  = r_fill + CW'(1);
                        w_taken = 1'b1;
                    end
                end
                xmbs_pkg::CMD_RX: begin
                    n_lv = 1'b1;
                    n_lb = s_axis_tdata;
                end
                xmbs_pkg::CMD_SLOT: begin
                    if (r_phase == xmbs_pkg::PH_SEND) begin
                        if (r_idx == IW'(0)) begin
                            w_ctl.sel = xmbs_pkg::SEL_IMM;
                            w_ctl.imm = r_long ? xmbs_pkg::TYPE_LONG : xmbs_pkg::TYPE_SHORT;
                        end else if (r_idx == IW'(1)) begin
                            w_ctl.sel = xmbs_pkg::SEL_IMM;
                            w_ctl.imm = r_block;
                        end else if (r_idx == IW'(2)) begin
                            w_ctl.sel = xmbs_pkg::SEL_IMM;
                            w_ctl.imm = ~r_block;
                        end else if (r_idx < w_len + IW'(3)) begin
                            if (MW'(w_d) < MW'(r_take)) begin
                                w_ctl.sel = xmbs_pkg::SEL_DATA;
                                w_re      = 1'b1;
                            end else begin
                                w_ctl.sel = xmbs_pkg::SEL_PAD;
                            end
                        end else if (r_crc && r_idx == w_len + IW'(3)) begin
                            w_ctl.sel = xmbs_pkg::SEL_CHK_HI;
                        end else begin
                            w_ctl.sel = xmbs_pkg::SEL_CHK_LO;
                        end
                        n_idx = r_idx + IW'(1);
                        if (n_idx >= w_total) begin
                            n_phase = xmbs_pkg::PH_WAIT_REPLY;
                        end
                    end else if (r_phase == xmbs_pkg::PH_SEND_END) begin
                        w_ctl.sel = xmbs_pkg::SEL_IMM;
                        w_ctl.imm = xmbs_pkg::CH_EOT;
                        n_phase   = xmbs_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase

            // block complete (also an empty block)
            if (n_phase == xmbs_pkg::PH_LOAD && n_fill >= r_take) begin
                n_rem = LENGTH_BITS'(MW'(r_rem) - MW'(r_take));
                if (r_start) begin
                    n_phase   = xmbs_pkg::PH_SEND;
                    n_idx     = '0;
                    w_ctl.clr = 1'b1;
                end else begin
                    n_phase = xmbs_pkg::PH_WAIT_START;
                end
            end

            // consume the partner byte
            if (n_lv && (n_phase == xmbs_pkg::PH_WAIT_START ||
                         n_phase == xmbs_pkg::PH_WAIT_REPLY)) begin
                n_lv = 1'b0;
                if (n_phase == xmbs_pkg::PH_WAIT_START) begin
                    if (n_lb == xmbs_pkg::CH_NAK || n_lb == xmbs_pkg::CH_CRC) begin
                        n_crc     = (n_lb == xmbs_pkg::CH_CRC);
                        n_start   = 1'b1;
                        n_phase   = xmbs_pkg::PH_SEND;
                        n_idx     = '0;
                        w_ctl.clr = 1'b1;
                    end else begin
                        w_ev = 1'b1;
                        w_eb = n_lb;
                    end
                end else if (n_lb == xmbs_pkg::CH_ACK) begin
                    if (n_rem != '0) begin
                        n_block = r_block + 8'd1;
                        w_size  = f_size(n_rem, r_force);
                        n_long  = w_size[CW];
                        n_take  = w_size[CW-1:0];
                        n_fill  = '0;
                        n_phase = xmbs_pkg::PH_LOAD;
                    end else begin
                        n_phase = xmbs_pkg::PH_SEND_END;
                    end
                end else begin
                    // any other reply: resend the block
                    n_phase   = xmbs_pkg::PH_SEND;
                    n_idx     = '0;
                    w_ctl.clr = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_force <= 1'b0;
            r_fill  <= '0;
            r_take  <= '0;
            r_long  <= 1'b0;
            r_rem   <= '0;
            r_block <= 8'd1;
            r_idx   <= '0;
            r_phase <= xmbs_pkg::PH_LOAD;
            r_start <= 1'b0;
            r_crc   <= 1'b0;
            r_lv    <= 1'b0;
            r_lb    <= 8'h00;
            r_mv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_force <= n_force;
            r_fill  <= n_fill;
            r_take  <= n_take;
            r_long  <= n_long;
            r_rem   <= n_rem;
            r_block <= n_block;
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_start <= n_start;
            r_crc   <= n_crc;
            r_lv    <= n_lv;
            r_lb    <= n_lb;
            if (w_acc) begin
                r_mv <= 1'b1;
            end else if (w_adv) begin
                r_mv <= 1'b0;
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // mid stage payload: byte control, taken and echo fields; phase and block number as they stand after the item
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_m_ctl   <= w_ctl;
            r_m_taken <= w_taken;
            r_m_ev    <= w_ev;
            r_m_eb    <= w_eb;
        end
    end

    logic [2:0] r_m_phase;
    logic [7:0] r_m_block;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_m_phase <= n_phase;
            r_m_block <= n_block;
        end
    end

    // ---------------------------------------------------------------------
    // Block store: written while loading, read while sending
    // ---------------------------------------------------------------------
    xmbs_ram #(
        .WIDTH (8),
        .DEPTH (LONG_BLOCK)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (w_re),
        .i_rd_addr (w_raddr),
        .o_rd_data (w_rdata)
    );

    xmbs_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_ctl     (r_m_ctl),
        .i_rd_data (w_rdata),
        .o_byte    (w_byte)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tdata <= {2'b00, r_m_block, r_m_phase, r_m_eb, r_m_ev, r_m_taken,
                        w_byte, (r_m_ctl.sel != xmbs_pkg::SEL_NONE)};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_tdata;

    // register readback
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {31'd0, r_force} : 32'(r_len);

endmodule

`default_nettype wire

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // command code with no meaning to the sender; it must leave state alone
    localparam logic [1:0] CMD_NONE         = 2'd3;
    // register map: image_length at 0, force_short at 4
    localparam logic [2:0] ADDR_IMAGE_LEN   = 3'd0;
    localparam logic [2:0] ADDR_FORCE_SHORT = 3'd4;
    localparam int         LONG_SIZE        = xmbs_pkg::LONG_BLOCK_DEF;
    localparam int         CYCLE_LIMIT      = 400000;
    localparam int         TAIL_ITEMS       = 20;

    // one result item, laid out as m_axis_tdata (lowest field last)
    typedef struct packed {
        logic [1:0] spare;
        logic [7:0] blk;
        logic [2:0] ph;
        logic [7:0] echo_b;
        logic       echo_v;
        logic       taken;
        logic [7:0] tx_b;
        logic       tx_v;
    } t_sender_out;

    // opening rows: every command, data extremes, partner bytes that are
    // latched during loading (the newer one wins and is echoed later)
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] d;
        logic       taken;
    } t_stim_row;

    t_stim_row opening_rows [0:13] = '{
        '{CMD_NONE,  8'hFF, 1'b0},
        '{CMD_NONE,  8'h00, 1'b0},
        '{xmbs_pkg::CMD_SLOT,  8'hFF, 1'b0},   // slot while loading: nothing goes out
        '{xmbs_pkg::CMD_SLOT,  8'h00, 1'b0},
        '{xmbs_pkg::CMD_RX,    8'h00, 1'b0},   // latched, then overwritten
        '{xmbs_pkg::CMD_RX,    8'hFF, 1'b0},
        '{xmbs_pkg::CMD_IMAGE, 8'h00, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, 8'hFF, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, 8'h55, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, 8'hAA, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, 8'h01, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, 8'h80, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, xmbs_pkg::PAD_BYTE, 1'b1},
        '{xmbs_pkg::CMD_IMAGE, xmbs_pkg::CH_EOT, 1'b1}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // data[7:0]
    logic [1:0]  s_axis_tuser = 2'd0;     // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // tx_valid, tx_byte, image_taken, echo_valid,
                                          // echo_byte, phase, current_block
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    xmodem_block_sender dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Sender predictor: register shadows and protocol state
    // ---------------------------------------------------------------
    logic [23:0] reg_len = 24'd0;
    logic        reg_short = 1'b0;

    logic [7:0]  img_store [0:LONG_SIZE-1];
    int unsigned n_filled = 0;
    int unsigned n_take = 0;          // empty image until length is written
    logic        long_blk = 1'b0;
    logic [23:0] bytes_left = 24'd0;
    logic [7:0]  blk_no = 8'd1;
    int unsigned line_pos = 0;
    logic [2:0]  proto = xmbs_pkg::PH_LOAD;
    logic        started = 1'b0;
    logic        crc_on = 1'b0;
    logic [15:0] chk_acc = 16'd0;
    logic [8:0]  rx_hold = 9'd0;      // bit 8 marks a pending partner byte

    // run statistics for the summary
    int n_items = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_echoes = 0;
    int n_resends = 0;
    int n_blocks = 0;
    int n_long = 0;

    t_sender_out pending_items [$];

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int cycle_cnt = 0;

    // CRC-16/0x1021, MSB first, one bit per step
    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0} ^ (fb ? xmbs_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // size the block from what is left and the force_short setting
    function void open_block();
        int unsigned span;
        long_blk = !reg_short && (bytes_left > xmbs_pkg::SHORT_BLOCK);
        span = long_blk ? LONG_SIZE : xmbs_pkg::SHORT_BLOCK;
        n_take = (bytes_left < span) ? 32'(bytes_left) : span;
        n_filled = 0;
        proto = xmbs_pkg::PH_LOAD;
    endfunction

    function void restart_send();
        proto = xmbs_pkg::PH_SEND;
        line_pos = 0;
        chk_acc = 16'd0;
    endfunction

    // header, data/padding, then sum or CRC (high byte first)
    function logic [7:0] next_line_byte(output logic block_done);
        int unsigned span;
        int unsigned total;
        int unsigned pos;
        logic [7:0]  b;
        span = long_blk ? LONG_SIZE : xmbs_pkg::SHORT_BLOCK;
        total = 3 + span + (crc_on ? 2 : 1);
        pos = line_pos;
        block_done = (pos + 1 >= total);
        if (pos == 0) begin
            b = long_blk ? xmbs_pkg::TYPE_LONG : xmbs_pkg::TYPE_SHORT;
        end else if (pos == 1) begin
            b = blk_no;
        end else if (pos == 2) begin
            b = ~blk_no;
        end else if (pos < 3 + span) begin
            b = (pos - 3 < n_take) ? img_store[pos - 3] : xmbs_pkg::PAD_BYTE;
            chk_acc = crc_on ? crc16_byte(chk_acc, b) : {8'h00, chk_acc[7:0] + b};
        end else if (crc_on && pos == 3 + span) begin
            b = chk_acc[15:8];
        end else begin
            b = chk_acc[7:0];
        end
        line_pos = pos + 1;
        return b;
    endfunction

    // register write; sizing is redone only while block 1 is untouched
    function void cfg_apply(logic [2:0] addr, logic [31:0] val);
        if (addr == ADDR_IMAGE_LEN) begin
            reg_len = val[23:0];
        end else if (addr == ADDR_FORCE_SHORT) begin
            reg_short = val[0];
        end else begin
            return;
        end
        if (proto == xmbs_pkg::PH_LOAD && blk_no == 8'd1 && n_filled == 0 && !started) begin
            bytes_left = reg_len;
            open_block();
        end
    endfunction

    // one accepted item in, one result item out
    function void sender_step(logic [1:0] cmd, logic [7:0] d, output t_sender_out r);
        logic       block_done;
        logic [7:0] rep;
        r = '0;
        case (cmd)
            xmbs_pkg::CMD_IMAGE: begin
                if (proto == xmbs_pkg::PH_LOAD && n_filled < n_take) begin
                    img_store[n_filled] = d;
                    n_filled++;
                    r.taken = 1'b1;
                end
            end
            xmbs_pkg::CMD_RX: begin
                rx_hold = {1'b1, d};
            end
            xmbs_pkg::CMD_SLOT: begin
                if (proto == xmbs_pkg::PH_SEND) begin
                    r.tx_v = 1'b1;
                    r.tx_b = next_line_byte(block_done);
                    if (block_done) begin
                        proto = xmbs_pkg::PH_WAIT_REPLY;
                        n_blocks++;
                        if (long_blk) n_long++;
                    end
                end else if (proto == xmbs_pkg::PH_SEND_END) begin
                    r.tx_v = 1'b1;
                    r.tx_b = xmbs_pkg::CH_EOT;
                    proto = xmbs_pkg::PH_DONE;
                end
            end
            default: ;
        endcase

        // block full: go straight to sending once the partner has started
        if (proto == xmbs_pkg::PH_LOAD && n_filled >= n_take) begin
            bytes_left = bytes_left - n_take[23:0];
            if (started) restart_send();
            else proto = xmbs_pkg::PH_WAIT_START;
        end

        // a latched byte is used on the item that enters a waiting phase too
        if (rx_hold[8] && (proto == xmbs_pkg::PH_WAIT_START ||
                           proto == xmbs_pkg::PH_WAIT_REPLY)) begin
            rep = rx_hold[7:0];
            rx_hold = 9'd0;
            if (proto == xmbs_pkg::PH_WAIT_START) begin
                if (rep == xmbs_pkg::CH_NAK || rep == xmbs_pkg::CH_CRC) begin
                    crc_on = (rep == xmbs_pkg::CH_CRC);
                    started = 1'b1;
                    restart_send();
                end else begin
                    r.echo_v = 1'b1;
                    r.echo_b = rep;
                    n_echoes++;
                end
            end else if (rep == xmbs_pkg::CH_ACK) begin
                if (bytes_left != 24'd0) begin
                    blk_no = blk_no + 8'd1;
                    open_block();
                end else begin
                    proto = xmbs_pkg::PH_SEND_END;
                end
            end else begin
                restart_send();
                n_resends++;
            end
        end
        r.ph = proto;
        r.blk = blk_no;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stalls and the field-by-field compare
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: result %0d %s mismatch, expected %0h, got %0h",
                     $time, n_results, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_mon
        t_sender_out got;
        t_sender_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_items.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %08h",
                         $time, m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_items.pop_front();
                check_field("tx_valid", 32'(want.tx_v), 32'(got.tx_v));
                check_field("tx_byte", 32'(want.tx_b), 32'(got.tx_b));
                check_field("image_taken", 32'(want.taken), 32'(got.taken));
                check_field("echo_valid", 32'(want.echo_v), 32'(got.echo_v));
                check_field("echo_byte", 32'(want.echo_b), 32'(got.echo_b));
                check_field("phase", 32'(want.ph), 32'(got.ph));
                check_field("current_block", 32'(want.blk), 32'(got.blk));
                check_field("spare bits", 32'(want.spare), 32'(got.spare));
                n_results++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still expected", $time,
                     pending_items.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // setup then access; the write lands on the edge with pready high
    task reg_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_apply(addr, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one item; called on a clock edge, returns on its accept edge
    task push_item(logic [1:0] cmd, logic [7:0] d, logic typed, t_sender_out typed_out);
        t_sender_out r;
        // idle pattern: sender sparse gaps, then heavy gaps, then none
        if (n_items < 500) begin
            src_gap_pct = 8;
            sink_stall_pct = 88;
        end else if (n_items < 1000) begin
            src_gap_pct = 88;
            sink_stall_pct = 8;
        end else begin
            src_gap_pct = 0;
            sink_stall_pct = 0;
        end
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sender_step(cmd, d, r);
        if (typed) r = typed_out;
        pending_items.push_back(r);
        n_items++;
    endtask

    // mostly well-formed traffic for the current phase, some noise
    task pick_item(logic [7:0] start_char, output logic [1:0] cmd, output logic [7:0] d);
        int unsigned roll;
        int unsigned ack_cut;
        roll = $urandom_range(0, 999);
        d = 8'($urandom_range(0, 255));
        cmd = xmbs_pkg::CMD_SLOT;
        case (proto)
            xmbs_pkg::PH_LOAD: begin
                if (roll < 930) cmd = xmbs_pkg::CMD_IMAGE;
                else if (roll < 960) cmd = xmbs_pkg::CMD_SLOT;
                else if (roll < 990) cmd = CMD_NONE;
                // a stray partner byte would turn into the reply; keep it
                // off long blocks so resends of those stay rare
                else if (roll < 994 && !long_blk) cmd = xmbs_pkg::CMD_RX;
                else cmd = xmbs_pkg::CMD_IMAGE;
            end
            xmbs_pkg::PH_WAIT_START: begin
                if (roll < 100) cmd = roll[0] ? xmbs_pkg::CMD_IMAGE : xmbs_pkg::CMD_SLOT;
                else begin
                    cmd = xmbs_pkg::CMD_RX;
                    if (roll >= 700) d = start_char;  // else echoed chatter
                end
            end
            xmbs_pkg::PH_SEND: begin
                if (roll < 985) cmd = xmbs_pkg::CMD_SLOT;
                else if (roll < 992) cmd = xmbs_pkg::CMD_IMAGE;
                else if (roll < 996 || long_blk) cmd = CMD_NONE;
                else cmd = xmbs_pkg::CMD_RX;
            end
            xmbs_pkg::PH_WAIT_REPLY: begin
                ack_cut = long_blk ? 990 : 700;
                if (roll < 50) cmd = roll[0] ? xmbs_pkg::CMD_IMAGE : xmbs_pkg::CMD_SLOT;
                else begin
                    cmd = xmbs_pkg::CMD_RX;
                    if (roll < ack_cut) d = xmbs_pkg::CH_ACK;
                    else if (roll % 3 == 0) d = xmbs_pkg::CH_NAK;
                    else if (roll % 3 == 1) d = xmbs_pkg::CH_CRC;
                end
            end
            xmbs_pkg::PH_SEND_END: begin
                if (roll < 900) cmd = xmbs_pkg::CMD_SLOT;
                else cmd = roll[0] ? xmbs_pkg::CMD_RX : CMD_NONE;
            end
            default: begin
                cmd = 2'($urandom_range(0, 3));
            end
        endcase
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [7:0]  d;
        logic [7:0]  start_char;
        logic [23:0] img_len;
        t_sender_out want_row;
        int          tail_left;
        logic        settled;
        int          n_drains;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Length chosen so the run gets a forced short block, then a long
        // block padded out because few bytes remain.
        img_len = 24'($urandom_range(258, 280));
        reg_write(ADDR_IMAGE_LEN, 32'hFFFF_FFFF);
        reg_write(ADDR_FORCE_SHORT, 32'd1);
        reg_write(ADDR_FORCE_SHORT, 32'd0);
        reg_write(ADDR_IMAGE_LEN, {8'hFF, img_len});   // upper bits are not stored
        reg_write(ADDR_FORCE_SHORT, 32'd1);
        // the partner picks the check mode once per transfer
        start_char = ($urandom_range(0, 1) != 0) ? xmbs_pkg::CH_CRC : xmbs_pkg::CH_NAK;

        // opening rows, results read straight off the loading phase
        foreach (opening_rows[i]) begin
            want_row = '0;
            want_row.taken = opening_rows[i].taken;
            want_row.ph = xmbs_pkg::PH_LOAD;
            want_row.blk = 8'd1;
            push_item(opening_rows[i].cmd, opening_rows[i].d, 1'b1, want_row);
        end

        // rest of the transfer, then some traffic after it has finished
        tail_left = TAIL_ITEMS;
        settled = 1'b0;
        n_drains = 0;
        while (tail_left > 0) begin
            if (proto == xmbs_pkg::PH_WAIT_REPLY && !settled) begin
                // block sent: let everything drain, then reconfigure; the
                // force_short write decides how the next ACK sizes a block
                s_axis_tvalid <= 1'b0;
                while (pending_items.size() != 0) @(posedge i_clk);
                repeat (4) @(posedge i_clk);
                reg_write(ADDR_FORCE_SHORT, 32'd0);
                // length writes mid-transfer must change nothing
                reg_write(ADDR_IMAGE_LEN, n_drains[0] ? 32'h0000_0000 : 32'h00FF_FFFF);
                n_drains++;
                settled = 1'b1;
            end
            if (proto != xmbs_pkg::PH_WAIT_REPLY) settled = 1'b0;
            if (proto == xmbs_pkg::PH_DONE) tail_left--;
            pick_item(start_char, cmd, d);
            push_item(cmd, d, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_items.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run: %0d items, %0d results, %0d blocks sent (%0d long), %0d resends",
                 n_items, n_results, n_blocks, n_long, n_resends);
        $display("Image of %0d bytes, %s check, %0d bytes echoed, last block number %0d",
                 img_len, crc_on ? "CRC-16" : "8-bit sum", n_echoes, blk_no);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
